// ===== hdl/ppr_pkg.sv =====
// ppr_pkg: widths, operation codes and status codes of the packet pre-buffer ring
// used by packet_prebuffer_ring_unit; depends on nothing

`default_nettype none

package ppr_pkg;

    localparam int RING_DEPTH_DEF  = 64;
    localparam int MAX_PAYLOAD_DEF = 262144;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int PSIZE_W  = 20;
    localparam int ESIZE_W  = 19;
    localparam int TS_W     = 64;
    localparam int STREAM_W = 8;
    localparam int FLAGS_W  = 16;
    localparam int SECS_W   = 32;
    localparam int CNT_W    = 7;
    localparam int BYTES_W  = 25;

    // stream word widths, padded to whole bytes
    localparam int IN_TDATA_W  = 208;
    localparam int OUT_FIELD_W = 274;
    localparam int OUT_TDATA_W = 280;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_RING_CAPACITY = 1'b0;
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // operations
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
    localparam logic [OP_W-1:0] OP_STATS = 2'd3;

    // result kinds
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ENTRY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/ppr_ram.sv =====
// ppr_ram: generic single-clock ram, one write port and one read port
// read data is registered and held until the next read; no dependencies

`default_nettype none

module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/packet_prebuffer_ring_unit.sv =====
// packet_prebuffer_ring_unit: overwrite-oldest ring of packet descriptors with stats
// depends on ppr_pkg and ppr_ram
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tuser op, tdata packet descriptor
//  m_axis    out        tvalid/tready/tlast    tuser status, tdata stats and entry
//  apb       in         psel/penable, pready=1 ring_capacity at byte address 0
//
// add, clear, stats, an oversize add and an empty flush are done in S_IDLE; an add on a
// full ring passes S_EVICT_RD and S_EVICT_OLD (S_EVICT_RD only at capacity 1), as the
// evicted and the new oldest slot are read one after the other through the single
// registered ram read port. flush issues the first read, then returns each slot in turn.
// reset clears indices, totals and state, not slots, which are never read before written.
// a word is taken only while the result register is empty or being emptied; a stalled
// m_axis holds the flush read in the ram output register.

`default_nettype none

module packet_prebuffer_ring_unit #(
    parameter int RING_DEPTH  = ppr_pkg::RING_DEPTH_DEF,
    parameter int MAX_PAYLOAD = ppr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // stream in
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: packet_size, present_time, decode_time, stream_number, packet_flags,
    //        wall_seconds, zero pad
    input  wire  [ppr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: op
    input  wire  [ppr_pkg::OP_W-1:0]          s_axis_tuser,
    // stream out
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // tdata: held_count, held_bytes, keyframes_held, oldest_seconds, newest_seconds,
    //        flushed_size, entry_present, entry_decode, entry_stream, entry_flags, zero pad
    output logic [ppr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: status
    output logic [ppr_pkg::STATUS_W-1:0]      m_axis_tuser,
    output logic                              m_axis_tlast,
    // register port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [ppr_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [ppr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ppr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CNT_W   = ppr_pkg::CNT_W;
    localparam int BYTES_W = ppr_pkg::BYTES_W;
    localparam int SECS_W  = ppr_pkg::SECS_W;
    localparam int TS_W    = ppr_pkg::TS_W;
    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int SIZE_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int OFF_PRES = SIZE_W;
    localparam int OFF_DEC  = OFF_PRES + TS_W;
    localparam int OFF_STR  = OFF_DEC + TS_W;
    localparam int OFF_FLG  = OFF_STR + ppr_pkg::STREAM_W;
    localparam int OFF_SEC  = OFF_FLG + ppr_pkg::FLAGS_W;
    localparam int SLOT_W   = OFF_SEC + SECS_W;

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_EVICT_RD  = 2'd1;
    localparam logic [1:0] S_EVICT_OLD = 2'd2;
    localparam logic [1:0] S_FLUSH     = 2'd3;

    // input fields
    logic [ppr_pkg::PSIZE_W-1:0]  in_size;
    logic [TS_W-1:0]              in_present;
    logic [TS_W-1:0]              in_decode;
    logic [ppr_pkg::STREAM_W-1:0] in_stream;
    logic [ppr_pkg::FLAGS_W-1:0]  in_flags;
    logic [SECS_W-1:0]            in_secs;
    logic [SLOT_W-1:0]            in_word;

    assign in_size    = s_axis_tdata[19:0];
    assign in_present = s_axis_tdata[83:20];
    assign in_decode  = s_axis_tdata[147:84];
    assign in_stream  = s_axis_tdata[155:148];
    assign in_flags   = s_axis_tdata[171:156];
    assign in_secs    = s_axis_tdata[203:172];
    assign in_word    = {in_secs, in_flags, in_stream, in_decode, in_present,
                         SIZE_W'(in_size)};

    // registers
    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cap_reg, cap_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [CNT_W-1:0]    key_reg, key_next;
    logic [SECS_W-1:0]   oldest_reg, oldest_next;
    logic [SECS_W-1:0]   newest_reg, newest_next;
    logic [SLOT_W-1:0]   hold_reg, hold_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    rd_left_reg, rd_left_next;
    logic [CNT_W-1:0]    out_left_reg, out_left_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                out_valid_reg, out_valid_next;
    logic [ppr_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic                            out_last_reg, out_last_next;
    logic [ppr_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // ram port
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [SLOT_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [SLOT_W-1:0] ram_rd_data;

    logic [CNT_W-1:0] cap_eff;
    logic             cfg_write;
    logic             in_accept;
    logic             can_load;

    ppr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (RING_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] s;
        s = CNT_W'(i) + CNT_W'(1);
        idx_wrap = (s == c) ? '0 : IDX_W'(s);
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(RING_DEPTH))
        begin
            cap_eff = CNT_W'(RING_DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == ppr_pkg::REG_RING_CAPACITY);
    assign prdata    = (paddr[2] == ppr_pkg::REG_RING_CAPACITY)
                       ? {{(ppr_pkg::APB_DATA_W - CNT_W){1'b0}}, cap_reg} : '0;

    assign can_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && can_load;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        logic             do_commit;
        logic [SLOT_W-1:0] c_word;
        logic             do_out;
        logic             ent_sel;
        logic             flush_issue;

        state_next   = state_reg;
        cap_next     = cap_reg;
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        fill_next    = fill_reg;
        bytes_next   = bytes_reg;
        key_next     = key_reg;
        oldest_next  = oldest_reg;
        newest_next  = newest_reg;
        hold_next    = hold_reg;
        pos_next     = pos_reg;
        rd_left_next = rd_left_reg;
        out_left_next = out_left_reg;
        rd_pend_next = rd_pend_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_idx_reg;
        ram_wr_data = in_word;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_idx_reg;

        do_commit = 1'b0;
        c_word    = in_word;
        do_out    = 1'b0;
        ent_sel   = 1'b0;
        flush_issue = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_axis_tuser)
                        ppr_pkg::OP_ADD:
                        begin
                            if (in_size > ppr_pkg::PSIZE_W'(MAX_PAYLOAD))
                            begin
                                do_out = 1'b1;
                                out_status_next = ppr_pkg::STAT_REJECTED;
                            end
                            else if (fill_reg >= cap_eff)
                            begin
                                // full: fetch the oldest slot first
                                hold_next  = in_word;
                                ram_rd_en  = 1'b1;
                                ram_rd_addr = rd_idx_reg;
                                state_next = S_EVICT_RD;
                            end
                            else
                            begin
                                do_commit = 1'b1;
                                c_word    = in_word;
                                do_out    = 1'b1;
                                out_status_next = ppr_pkg::STAT_OK;
                            end
                        end
                        ppr_pkg::OP_CLEAR:
                        begin
                            wr_idx_next = '0;
                            rd_idx_next = '0;
                            fill_next   = '0;
                            bytes_next  = '0;
                            key_next    = '0;
                            oldest_next = '0;
                            newest_next = '0;
                            do_out = 1'b1;
                            out_status_next = ppr_pkg::STAT_OK;
                        end
                        ppr_pkg::OP_FLUSH:
                        begin
                            if (fill_reg == '0)
                            begin
                                do_out = 1'b1;
                                out_status_next = ppr_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                pos_next      = rd_idx_reg;
                                rd_left_next  = fill_reg;
                                out_left_next = fill_reg;
                                rd_pend_next  = 1'b0;
                                state_next    = S_FLUSH;
                            end
                        end
                        default:
                        begin
                            do_out = 1'b1;
                            out_status_next = ppr_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            S_EVICT_RD:
            begin
                bytes_next  = bytes_reg - BYTES_W'(ram_rd_data[SIZE_W-1:0]);
                if (ram_rd_data[OFF_FLG] && (key_reg != '0))
                begin
                    key_next = key_reg - CNT_W'(1);
                end
                rd_idx_next = idx_wrap(rd_idx_reg, cap_eff);
                fill_next   = fill_reg - CNT_W'(1);
                if (fill_next != '0)
                begin
                    // the new oldest slot supplies the oldest time
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_idx_next;
                    state_next  = S_EVICT_OLD;
                end
                else
                begin
                    do_commit  = 1'b1;
                    c_word     = hold_reg;
                    do_out     = 1'b1;
                    out_status_next = ppr_pkg::STAT_OK;
                    state_next = S_IDLE;
                end
            end
            S_EVICT_OLD:
            begin
                oldest_next = ram_rd_data[OFF_SEC +: SECS_W];
                do_commit   = 1'b1;
                c_word      = hold_reg;
                do_out      = 1'b1;
                out_status_next = ppr_pkg::STAT_OK;
                state_next  = S_IDLE;
            end
            S_FLUSH:
            begin
                if (rd_pend_reg && can_load)
                begin
                    do_out  = 1'b1;
                    ent_sel = 1'b1;
                    out_status_next = ppr_pkg::STAT_ENTRY;
                    out_left_next   = out_left_reg - CNT_W'(1);
                    if (out_left_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
                flush_issue = (rd_left_reg != '0) && (!rd_pend_reg || can_load);
                if (flush_issue)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = pos_reg;
                    pos_next     = idx_wrap(pos_reg, cap_eff);
                    rd_left_next = rd_left_reg - CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                else if (do_out)
                begin
                    rd_pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_commit)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_idx_reg;
            ram_wr_data = c_word;
            wr_idx_next = idx_wrap(wr_idx_reg, cap_eff);
            fill_next   = fill_next + CNT_W'(1);
            bytes_next  = bytes_next + BYTES_W'(c_word[SIZE_W-1:0]);
            newest_next = c_word[OFF_SEC +: SECS_W];
            if (fill_next == CNT_W'(1))
            begin
                oldest_next = c_word[OFF_SEC +: SECS_W];
            end
            if (c_word[OFF_FLG])
            begin
                key_next = key_next + CNT_W'(1);
            end
        end

        if (do_out)
        begin
            out_last_next = (state_reg == S_FLUSH) ? (out_left_reg == CNT_W'(1)) : 1'b1;
            if (ent_sel)
            begin
                out_data_next = {{ppr_pkg::OUT_PAD_W{1'b0}},
                                 ram_rd_data[OFF_FLG +: ppr_pkg::FLAGS_W],
                                 ram_rd_data[OFF_STR +: ppr_pkg::STREAM_W],
                                 ram_rd_data[OFF_DEC +: TS_W],
                                 ram_rd_data[OFF_PRES +: TS_W],
                                 ppr_pkg::ESIZE_W'(ram_rd_data[SIZE_W-1:0]),
                                 newest_next, oldest_next, key_next, bytes_next,
                                 fill_next};
            end
            else
            begin
                out_data_next = {{ppr_pkg::OUT_PAD_W{1'b0}},
                                 {(ppr_pkg::FLAGS_W + ppr_pkg::STREAM_W + 2 * TS_W
                                   + ppr_pkg::ESIZE_W){1'b0}},
                                 newest_next, oldest_next, key_next, bytes_next,
                                 fill_next};
            end
        end

        // a capacity write also empties the ring
        if (cfg_write)
        begin
            cap_next    = pwdata[CNT_W-1:0];
            wr_idx_next = '0;
            rd_idx_next = '0;
            fill_next   = '0;
            bytes_next  = '0;
            key_next    = '0;
            oldest_next = '0;
            newest_next = '0;
        end

        out_valid_next = do_out ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= ppr_pkg::CAP_RESET;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            fill_reg      <= '0;
            bytes_reg     <= '0;
            key_reg       <= '0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            rd_left_reg   <= '0;
            out_left_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            fill_reg      <= fill_next;
            bytes_reg     <= bytes_next;
            key_reg       <= key_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            rd_left_reg   <= rd_left_next;
            out_left_reg  <= out_left_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg       <= hold_next;
        pos_reg        <= pos_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_data_reg   <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
